[design/icc_pkg.sv]
// ----------------------------------------------------------------------------
// icc_pkg
// Shared types and constants of the index coordinate converter: field widths,
// command and register codes and the beat that travels along the cell chain.
// ----------------------------------------------------------------------------
package icc_pkg;

    localparam int DIMS      = 4;
    localparam int DIM_W     = 2;
    localparam int COORD_W   = 16;
    localparam int LIN_W     = 64;
    localparam int CNT_W     = 3;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    // Quotient bits resolved by one division cell.
    localparam int DIV_BITS  = 4;
    localparam int DIV_CELLS = LIN_W / DIV_BITS;
    // One multiply-accumulate cell plus the division cells for each dimension.
    localparam int SEG_LEN   = DIV_CELLS + 1;
    localparam int CHAIN_LEN = DIMS * SEG_LEN;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [LIN_W-1:0]   lin_t;

    typedef enum logic
    {
        CMD_TO_LINEAR = 1'b0,
        CMD_TO_COORD  = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        REG_DIM_COUNT  = 3'd0,
        REG_DIM_SIZE_0 = 3'd1,
        REG_DIM_SIZE_1 = 3'd2,
        REG_DIM_SIZE_2 = 3'd3,
        REG_DIM_SIZE_3 = 3'd4
    } reg_idx_t;

    // Item state carried from cell to cell. The word holds the running index
    // sum when linearising and the remaining dividend/quotient when splitting.
    typedef struct packed
    {
        logic                  vld;
        cmd_t                  cmd;
        lin_t                  word;
        coord_t                rem;
        coord_t [DIMS-1:0]     coord;
    } beat_t;

endpackage

[design/icc_stream_if.sv]
// ----------------------------------------------------------------------------
// icc_stream_if
// Valid/ready channels of the converter: the request and the response.
// ----------------------------------------------------------------------------
interface icc_req_if
    import icc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [CNT_W-1:0]   coord_count;
    logic [COORD_W-1:0] coord_in_0;
    logic [COORD_W-1:0] coord_in_1;
    logic [COORD_W-1:0] coord_in_2;
    logic [COORD_W-1:0] coord_in_3;
    logic [LIN_W-1:0]   linear_in;

    modport source
    (
        output valid, cmd, coord_count, coord_in_0, coord_in_1, coord_in_2,
               coord_in_3, linear_in,
        input  ready
    );

    modport sink
    (
        input  valid, cmd, coord_count, coord_in_0, coord_in_1, coord_in_2,
               coord_in_3, linear_in,
        output ready
    );
endinterface

interface icc_rsp_if
    import icc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LIN_W-1:0]   linear_out;
    logic [COORD_W-1:0] coord_out_0;
    logic [COORD_W-1:0] coord_out_1;
    logic [COORD_W-1:0] coord_out_2;
    logic [COORD_W-1:0] coord_out_3;

    modport source
    (
        output valid, linear_out, coord_out_0, coord_out_1, coord_out_2,
               coord_out_3,
        input  ready
    );

    modport sink
    (
        input  valid, linear_out, coord_out_0, coord_out_1, coord_out_2,
               coord_out_3,
        output ready
    );
endinterface

[design/icc_mac_cell.sv]
// ----------------------------------------------------------------------------
// icc_mac_cell
// One Horner step of the linearisation (sum times size plus coordinate). For
// a split it files the remainder of the previous dimension's division.
// ----------------------------------------------------------------------------
module icc_mac_cell
    import icc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [DIM_W-1:0]   dim,
    input  logic [COORD_W-1:0] size,
    input  beat_t              beat_in,
    output beat_t              beat_out
);

    beat_t            beat_reg;
    beat_t            beat_next;
    logic [DIM_W-1:0] slot;

    // The division before this cell worked on dimension DIMS minus dim (modulo DIMS).
    assign slot = DIM_W'(-{1'b0, dim});

    // Next beat.
    always_comb
    begin
        beat_next = beat_in;
        if (beat_in.cmd == CMD_TO_LINEAR)
        begin
            beat_next.word = LIN_W'(beat_in.word * {{(LIN_W-COORD_W){1'b0}}, size})
                           + {{(LIN_W-COORD_W){1'b0}}, beat_in.coord[dim]};
        end
        else
        begin
            beat_next.coord[slot] = beat_in.rem;
            beat_next.rem         = '0;
        end
    end

    // Beat register; reset empties the cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= '0;
        end
        else if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

[design/icc_div_cell.sv]
// ----------------------------------------------------------------------------
// icc_div_cell
// Restoring division cell: shifts DIV_BITS (four) dividend bits into the partial
// remainder and shifts the quotient bits in behind them.
// ----------------------------------------------------------------------------
module icc_div_cell
    import icc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [COORD_W-1:0] size,
    input  beat_t              beat_in,
    output beat_t              beat_out
);

    beat_t beat_reg;
    beat_t beat_next;

    // Division steps; the partial remainder stays below the divisor.
    always_comb
    begin
        logic [COORD_W:0]   trial;
        logic [COORD_W-1:0] r;
        lin_t               w;
        r         = beat_in.rem;
        w         = beat_in.word;
        beat_next = beat_in;
        for (int j = 0; j < DIV_BITS; j++)
        begin
            trial = {r, w[LIN_W-1]};
            w     = {w[LIN_W-2:0], 1'b0};
            if (trial >= {1'b0, size})
            begin
                trial = trial - {1'b0, size};
                w[0]  = 1'b1;
            end
            r = trial[COORD_W-1:0];
        end
        if (beat_in.cmd == CMD_TO_COORD)
        begin
            beat_next.rem  = r;
            beat_next.word = w;
        end
    end

    // Beat register; reset empties the cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= '0;
        end
        else if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

[design/index_coordinate_converter.sv]
// Each accepted request beat passes the whole cell chain and then the response register.
// Throughput: one beat per cycle; a held response stalls the whole cell chain.
// The chain has one multiply-accumulate cell and 16 four-bit division cells
// per dimension, so the 64-bit restoring division sets the depth.
// Reset: dim_count and all sizes return to 1 and the chain empties at once.
// ----------------------------------------------------------------------------
// index_coordinate_converter
// Row-major conversion between a coordinate of up to four dimensions and a
// linear element index, with an APB-style register port for the sizes.
// ----------------------------------------------------------------------------
module index_coordinate_converter
    import icc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    icc_req_if.sink           req,
    icc_rsp_if.source         rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [CNT_W-1:0]           dim_count_reg;
    coord_t [DIMS-1:0]          dim_size_reg;
    logic [CNT_W-1:0]           n_use;
    coord_t [DIMS-1:0]          size_eff;
    reg_idx_t                   reg_idx;
    logic                       en;
    beat_t                      entry;
    beat_t [CHAIN_LEN:0]        chain;
    logic                       out_valid_reg;
    lin_t                       linear_reg;
    coord_t [DIMS-1:0]          coord_reg;
    lin_t                       linear_next;
    coord_t [DIMS-1:0]          coord_next;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg <= CNT_W'(1);
            dim_size_reg  <= {DIMS{COORD_W'(1)}};
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx)
                REG_DIM_COUNT:  dim_count_reg   <= pwdata[CNT_W-1:0];
                REG_DIM_SIZE_0: dim_size_reg[0] <= pwdata[COORD_W-1:0];
                REG_DIM_SIZE_1: dim_size_reg[1] <= pwdata[COORD_W-1:0];
                REG_DIM_SIZE_2: dim_size_reg[2] <= pwdata[COORD_W-1:0];
                REG_DIM_SIZE_3: dim_size_reg[3] <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (reg_idx)
            REG_DIM_COUNT:  prdata = {{(DATA_W-CNT_W){1'b0}}, dim_count_reg};
            REG_DIM_SIZE_0: prdata = {{(DATA_W-COORD_W){1'b0}}, dim_size_reg[0]};
            REG_DIM_SIZE_1: prdata = {{(DATA_W-COORD_W){1'b0}}, dim_size_reg[1]};
            REG_DIM_SIZE_2: prdata = {{(DATA_W-COORD_W){1'b0}}, dim_size_reg[2]};
            REG_DIM_SIZE_3: prdata = {{(DATA_W-COORD_W){1'b0}}, dim_size_reg[3]};
            default:        prdata = '0;
        endcase
    end

    // Dimensions in use and effective sizes; an unused dimension acts as size
    // one, which leaves the sum unchanged and yields a zero coordinate.
    always_comb
    begin
        if (dim_count_reg == '0)
        begin
            n_use = CNT_W'(1);
        end
        else if (dim_count_reg > CNT_W'(DIMS))
        begin
            n_use = CNT_W'(DIMS);
        end
        else
        begin
            n_use = dim_count_reg;
        end
        for (int d = 0; d < DIMS; d++)
        begin
            if (CNT_W'(d) < n_use && dim_size_reg[d] != '0)
            begin
                size_eff[d] = dim_size_reg[d];
            end
            else
            begin
                size_eff[d] = COORD_W'(1);
            end
        end
    end

    // The chain moves whenever the response register is free or being taken.
    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    // Entry beat: coordinates beyond those given or in use are zeroed.
    always_comb
    begin
        coord_t [DIMS-1:0] cin;
        cin         = {req.coord_in_3, req.coord_in_2, req.coord_in_1, req.coord_in_0};
        entry.vld   = req.valid;
        entry.cmd   = cmd_t'(req.cmd);
        entry.rem   = '0;
        entry.word  = (entry.cmd == CMD_TO_COORD) ? req.linear_in : '0;
        for (int d = 0; d < DIMS; d++)
        begin
            if (entry.cmd == CMD_TO_LINEAR && CNT_W'(d) < req.coord_count
                && CNT_W'(d) < n_use)
            begin
                entry.coord[d] = cin[d];
            end
            else
            begin
                entry.coord[d] = '0;
            end
        end
    end

    assign chain[0] = entry;

    // Cell chain: segment k accumulates dimension k and then divides by the
    // size of the mirrored dimension.
    for (genvar k = 0; k < DIMS; k++)
    begin : g_seg
        icc_mac_cell u_mac
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .dim      (DIM_W'(k)),
            .size     (size_eff[k]),
            .beat_in  (chain[k*SEG_LEN]),
            .beat_out (chain[k*SEG_LEN+1])
        );
        for (genvar j = 0; j < DIV_CELLS; j++)
        begin : g_div
            icc_div_cell u_div
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .size     (size_eff[DIMS-1-k]),
                .beat_in  (chain[k*SEG_LEN+1+j]),
                .beat_out (chain[k*SEG_LEN+2+j])
            );
        end
    end

    // Response formation: the last remainder is coordinate zero.
    always_comb
    begin
        if (chain[CHAIN_LEN].cmd == CMD_TO_LINEAR)
        begin
            linear_next = chain[CHAIN_LEN].word;
            coord_next  = '0;
        end
        else
        begin
            linear_next   = '0;
            coord_next    = chain[CHAIN_LEN].coord;
            coord_next[0] = chain[CHAIN_LEN].rem;
        end
    end

    // Response register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chain[CHAIN_LEN].vld;
        end
    end

    // Response register payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            linear_reg <= linear_next;
            coord_reg  <= coord_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.linear_out  = linear_reg;
    assign rsp.coord_out_0 = coord_reg[0];
    assign rsp.coord_out_1 = coord_reg[1];
    assign rsp.coord_out_2 = coord_reg[2];
    assign rsp.coord_out_3 = coord_reg[3];

    // A held response must stop the request side.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !req.ready)
        else $error("request accepted while response is held");

    // An accepted beat enters the first cell.
    a_accept_enters_chain: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> chain[1].vld)
        else $error("accepted beat lost at the chain entry");

    // A response carries either an index or coordinates, never both.
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.linear_out == '0) || (coord_reg == '0))
        else $error("response carries both index and coordinates");

endmodule
